[hdl/three_axis_moving_average_assert.svh]
// assertion macros for the three-axis moving average
// expects clk and rst_n in the scope of each use
`ifndef THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define TAMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tama_pkg.sv]
// shared constants, types and divider interface structs
// used by tama_div and three_axis_moving_average; no dependencies
package tama_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int AXES       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W      = IDX_W + 1;
    localparam int ACC_W      = SAMPLE_W + IDX_W;
    localparam int STEP_W     = $clog2(ACC_W);
    localparam int LEN_RESET  = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [IDX_W-1:0]           idx_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hdl/tama_div.sv]
// three-lane bit-serial signed divider, one quotient bit per lane per cycle
// truncates toward zero; depends on tama_pkg
module tama_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tama_pkg::div_ctrl_t   ctrl,
    input  tama_pkg::acc_t        dividend [tama_pkg::AXES],
    input  tama_pkg::len_t        divisor,
    output tama_pkg::div_stat_t   stat,
    output tama_pkg::sample_t     quotient [tama_pkg::AXES]
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tama_pkg::STEP_W-1:0]     step_reg, step_next;
    tama_pkg::len_t                  div_reg, div_next;
    logic                            neg_reg  [tama_pkg::AXES];
    logic                            neg_next [tama_pkg::AXES];
    logic [tama_pkg::ACC_W-1:0]      mag_reg  [tama_pkg::AXES];
    logic [tama_pkg::ACC_W-1:0]      mag_next [tama_pkg::AXES];
    logic [tama_pkg::LEN_W-1:0]      rem_reg  [tama_pkg::AXES];
    logic [tama_pkg::LEN_W-1:0]      rem_next [tama_pkg::AXES];
    logic [tama_pkg::LEN_W:0]        rem_shift [tama_pkg::AXES];
    logic                            rem_ge    [tama_pkg::AXES];
    logic [tama_pkg::ACC_W-1:0]      q_full    [tama_pkg::AXES];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        div_next  = div_reg;
        for (int a = 0; a < tama_pkg::AXES; a++)
        begin
            rem_shift[a] = {rem_reg[a], mag_reg[a][tama_pkg::ACC_W-1]};
            rem_ge[a]    = rem_shift[a] >= {1'b0, div_reg};
            neg_next[a]  = neg_reg[a];
            mag_next[a]  = mag_reg[a];
            rem_next[a]  = rem_reg[a];
            q_full[a]    = neg_reg[a] ? (~mag_reg[a] + tama_pkg::ACC_W'(1)) : mag_reg[a];
            quotient[a]  = q_full[a][tama_pkg::SAMPLE_W-1:0];
        end
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            div_next  = divisor;
            for (int a = 0; a < tama_pkg::AXES; a++)
            begin
                neg_next[a] = dividend[a][tama_pkg::ACC_W-1];
                mag_next[a] = dividend[a][tama_pkg::ACC_W-1]
                            ? (~dividend[a] + tama_pkg::ACC_W'(1)) : dividend[a];
                rem_next[a] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int a = 0; a < tama_pkg::AXES; a++)
            begin
                mag_next[a] = {mag_reg[a][tama_pkg::ACC_W-2:0], rem_ge[a]};
                rem_next[a] = rem_ge[a]
                            ? tama_pkg::LEN_W'(rem_shift[a] - {1'b0, div_reg})
                            : rem_shift[a][tama_pkg::LEN_W-1:0];
            end
            if (step_reg == tama_pkg::STEP_W'(tama_pkg::ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + tama_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        for (int a = 0; a < tama_pkg::AXES; a++)
        begin
            neg_reg[a] <= neg_next[a];
            mag_reg[a] <= mag_next[a];
            rem_reg[a] <= rem_next[a];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hdl/three_axis_moving_average.sv]
// a warm-up passthrough is registered into the result, held in ST_DONE, then loaded into
// the output registers; an average (n = effective window length, 1..32) walks the sample
// store one row per cycle, runs the bit-serial divider and is handed off the same way
// a new sample is taken only in idle, once the last result is in the output registers;
// a result waits in ST_DONE while the output registers hold one not yet transferred
// reset: async active low; index 0, warm-up on, length 15, store reads as zero
`include "three_axis_moving_average_assert.svh"

module three_axis_moving_average (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [tama_pkg::LEN_W-1:0]   cfg_data,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  logic signed [15:0]           sample_x,
    input  logic signed [15:0]           sample_y,
    input  logic signed [15:0]           sample_z,
    output logic                         mean_valid,
    input  logic                         mean_ready,
    output logic signed [15:0]           mean_x,
    output logic signed [15:0]           mean_y,
    output logic signed [15:0]           mean_z,
    output logic                         averaged
);

    localparam int ROW_W = tama_pkg::AXES * tama_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    tama_pkg::len_t                  window_length_reg;
    tama_pkg::len_t                  eff_len;
    tama_pkg::len_t                  idx_plus;
    tama_pkg::idx_t                  write_index_reg, write_index_next;
    logic                            warming_reg, warming_next;
    tama_pkg::len_t                  len_reg, len_next;
    tama_pkg::len_t                  cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    tama_pkg::acc_t                  acc_reg  [tama_pkg::AXES];
    tama_pkg::acc_t                  acc_next [tama_pkg::AXES];
    tama_pkg::sample_t               res_reg  [tama_pkg::AXES];
    tama_pkg::sample_t               res_next [tama_pkg::AXES];
    logic                            res_avg_reg, res_avg_next;
    logic                            mean_valid_reg, mean_valid_next;
    tama_pkg::sample_t               mean_reg  [tama_pkg::AXES];
    logic                            averaged_reg;
    logic                            load_out;
    logic                            accept;
    logic                            rd_en;
    logic [ROW_W-1:0]                wr_row;
    logic [ROW_W-1:0]                row_mem [tama_pkg::WINDOW_MAX];
    logic [ROW_W-1:0]                rd_row_reg;
    logic                            rd_vld_reg;
    logic [tama_pkg::WINDOW_MAX-1:0] vld_reg;
    tama_pkg::sample_t               sample_in [tama_pkg::AXES];
    tama_pkg::sample_t               rd_lane   [tama_pkg::AXES];
    tama_pkg::div_ctrl_t             div_ctrl;
    tama_pkg::div_stat_t             div_stat;
    tama_pkg::sample_t               quotient  [tama_pkg::AXES];

    assign sample_in[0] = sample_x;
    assign sample_in[1] = sample_y;
    assign sample_in[2] = sample_z;
    assign wr_row       = {sample_z, sample_y, sample_x};

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        if (window_length_reg == '0)
            eff_len = tama_pkg::LEN_W'(1);
        else if (window_length_reg > tama_pkg::LEN_W'(tama_pkg::WINDOW_MAX))
            eff_len = tama_pkg::LEN_W'(tama_pkg::WINDOW_MAX);
        else
            eff_len = window_length_reg;
    end

    assign idx_plus = {1'b0, write_index_reg} + tama_pkg::LEN_W'(1);

    always_comb
    begin
        for (int a = 0; a < tama_pkg::AXES; a++)
            rd_lane[a] = rd_vld_reg ? rd_row_reg[a*tama_pkg::SAMPLE_W +: tama_pkg::SAMPLE_W]
                                    : '0;
    end

    always_comb
    begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        warming_next     = warming_reg;
        len_next         = len_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        res_avg_next     = res_avg_reg;
        rd_en            = 1'b0;
        div_ctrl.start   = 1'b0;
        load_out         = 1'b0;
        for (int a = 0; a < tama_pkg::AXES; a++)
        begin
            acc_next[a] = acc_reg[a];
            res_next[a] = res_reg[a];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (warming_reg && (idx_plus < eff_len))
                    begin
                        write_index_next = idx_plus[tama_pkg::IDX_W-1:0];
                        for (int a = 0; a < tama_pkg::AXES; a++)
                            res_next[a] = sample_in[a];
                        res_avg_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        warming_next     = 1'b0;
                        write_index_next = (idx_plus >= eff_len)
                                         ? '0 : idx_plus[tama_pkg::IDX_W-1:0];
                        len_next         = eff_len;
                        cnt_next         = '0;
                        for (int a = 0; a < tama_pkg::AXES; a++)
                            acc_next[a] = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (cnt_reg < len_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + tama_pkg::LEN_W'(1);
                end
                if (pend_reg)
                begin
                    for (int a = 0; a < tama_pkg::AXES; a++)
                        acc_next[a] = acc_reg[a] + tama_pkg::ACC_W'(rd_lane[a]);
                end
                else if (cnt_reg == len_reg)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    for (int a = 0; a < tama_pkg::AXES; a++)
                        res_next[a] = quotient[a];
                    res_avg_next = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mean_valid_reg || mean_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mean_valid_next = mean_valid_reg;
        if (mean_valid_reg && mean_ready)
            mean_valid_next = 1'b0;
        if (load_out)
            mean_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= tama_pkg::LEN_W'(tama_pkg::LEN_RESET);
            write_index_reg   <= '0;
            warming_reg       <= 1'b1;
            len_reg           <= '0;
            cnt_reg           <= '0;
            pend_reg          <= 1'b0;
            mean_valid_reg    <= 1'b0;
            vld_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_index_reg <= write_index_next;
            warming_reg     <= warming_next;
            len_reg         <= len_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
            mean_valid_reg  <= mean_valid_next;
            if (cfg_write)
                window_length_reg <= cfg_data;
            if (accept)
                vld_reg[write_index_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_avg_reg <= res_avg_next;
        for (int a = 0; a < tama_pkg::AXES; a++)
        begin
            acc_reg[a] <= acc_next[a];
            res_reg[a] <= res_next[a];
        end
        if (load_out)
        begin
            averaged_reg <= res_avg_reg;
            for (int a = 0; a < tama_pkg::AXES; a++)
                mean_reg[a] <= res_reg[a];
        end
    end

    // sample store, one row of three axes per entry
    always_ff @(posedge clk)
    begin
        if (accept)
            row_mem[write_index_reg] <= wr_row;
        if (rd_en)
        begin
            rd_row_reg <= row_mem[cnt_reg[tama_pkg::IDX_W-1:0]];
            rd_vld_reg <= vld_reg[cnt_reg[tama_pkg::IDX_W-1:0]];
        end
    end

    tama_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (acc_reg),
        .divisor  (len_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign mean_valid = mean_valid_reg;
    assign mean_x     = mean_reg[0];
    assign mean_y     = mean_reg[1];
    assign mean_z     = mean_reg[2];
    assign averaged   = averaged_reg;

    `TAMA_ASSERT_NEXT(a_busy_after_transfer, accept, !sample_ready, "ready after transfer")
    `TAMA_ASSERT_NOW(a_avg_after_warmup, mean_valid && averaged, !warming_reg, "average in warm-up")
    `TAMA_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_reg == ST_DIV, "done outside divide")
    `TAMA_ASSERT_NOW(a_div_busy_in_div, div_stat.busy, state_reg == ST_DIV, "busy outside divide")
    `TAMA_ASSERT_NOW(a_walk_in_range, state_reg == ST_SUM, cnt_reg <= len_reg, "walk past window")

endmodule
